// ----- sv/ohrb_pkg.sv -----
// ---------------------------------------------------------------------------
// ohrb_pkg: shared types and constants for the history ring buffer
// Command codes, queued operation classes and fixed field widths.
// ---------------------------------------------------------------------------
`default_nettype none

package ohrb_pkg;

	// fixed field widths of the ports
	localparam int CNT_W = 5;   // read_count, capacity, fill_level
	localparam int AGE_W = 4;   // age

	// capacity after reset, before clamping to the ring depth
	localparam int CAP_RESET = 16;

	// queue between front and back (power of two, pointers wrap naturally)
	localparam int QDEPTH = 2;

	// input command codes
	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// operation class decided by the front
	typedef enum logic [1:0] {
		OP_STORE     = 2'd0,
		OP_READ      = 2'd1,
		OP_READ_NONE = 2'd2
	} op_t;

endpackage

`default_nettype wire

// ----- sv/ohrb_front.sv -----
// ---------------------------------------------------------------------------
// ohrb_front: command intake
// Accepts items, classifies them and holds them in a short queue for the
// back end.
// ---------------------------------------------------------------------------
`default_nettype none

module ohrb_front #(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic                    cmd,
	input  wire logic [DATA_WIDTH-1:0]   data_in,
	input  wire logic [ohrb_pkg::CNT_W-1:0] read_count,
	output logic                         busy,
	output logic                         empty,
	output logic                         head_valid,
	output ohrb_pkg::op_t                head_op,
	output logic [DATA_WIDTH-1:0]        head_data,
	output logic [ohrb_pkg::CNT_W-1:0]   head_count,
	input  wire logic                    pop
);
	import ohrb_pkg::*;

	localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW = $clog2(QDEPTH + 1);

	op_t                   op_q    [QDEPTH];
	logic [DATA_WIDTH-1:0] data_q  [QDEPTH];
	logic [CNT_W-1:0]      count_q [QDEPTH];
	logic [QPW-1:0]        wr_ptr_q;
	logic [QPW-1:0]        rd_ptr_q;
	logic [QCW-1:0]        level_q;
	logic                  push;
	op_t                   op_new;

	// classify the incoming item
	always_comb begin
		if (cmd == CMD_STORE) begin
			op_new = OP_STORE;
		end else if (read_count == '0) begin
			op_new = OP_READ_NONE;
		end else begin
			op_new = OP_READ;
		end
	end

	assign busy       = (level_q == QCW'(QDEPTH));
	assign empty      = (level_q == '0);
	assign push       = start & ~busy;
	assign head_valid = ~empty;
	assign head_op    = op_q[rd_ptr_q];
	assign head_data  = data_q[rd_ptr_q];
	assign head_count = count_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q]    <= op_new;
			data_q[wr_ptr_q]  <= data_in;
			count_q[wr_ptr_q] <= read_count;
		end
	end

	// queue pointers and level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + QCW'(1);
			end else if (pop && !push) begin
				level_q <= level_q - QCW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/ohrb_back.sv -----
// ---------------------------------------------------------------------------
// ohrb_back: ring engine
// Owns the ring memory, write pointer, fill count and capacity; executes
// stores and streams reads newest first, one result per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ohrb_back #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       head_valid,
	input  wire ohrb_pkg::op_t              head_op,
	input  wire logic [DATA_WIDTH-1:0]      head_data,
	input  wire logic [ohrb_pkg::CNT_W-1:0] head_count,
	output logic                            pop,
	output logic                            idle,
	input  wire logic                       cfg_we,
	input  wire logic [ohrb_pkg::CNT_W-1:0] cfg_data,
	output logic                            result_valid,
	output logic [DATA_WIDTH-1:0]           data_out,
	output logic [ohrb_pkg::AGE_W-1:0]      age,
	output logic                            has_data,
	output logic                            last,
	output logic [ohrb_pkg::CNT_W-1:0]      fill_level,
	output logic                            is_empty,
	output logic                            is_full
);
	import ohrb_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int CW = (FW > CNT_W) ? FW : CNT_W;
	localparam int CAP_INIT = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_STREAM = 2'b10
	} state_t;

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	state_t                state_q;
	logic [PW-1:0]         wp_q;
	logic [FW-1:0]         fill_q;
	logic [FW-1:0]         cap_q;
	logic [PW-1:0]         rd_ptr_q;
	logic [CW-1:0]         age_q;
	logic [CW-1:0]         last_age_q;

	logic                  result_valid_s2;
	logic [DATA_WIDTH-1:0] rdata_s2;
	logic [AGE_W-1:0]      age_s2;
	logic                  has_s2;
	logic                  last_s2;
	logic [CNT_W-1:0]      fill_s2;
	logic                  empty_s2;
	logic                  full_s2;

	logic                  issue;
	logic                  mem_we;
	logic [PW-1:0]         rd_addr;
	logic [PW-1:0]         dec_addr;
	logic [PW-1:0]         wp_prev;
	logic [PW-1:0]         wp_next;
	logic [FW-1:0]         fill_next;
	logic [CW-1:0]         age_cur;
	logic                  has_cur;
	logic                  last_cur;
	logic [CW-1:0]         avail;
	logic [CW-1:0]         req;
	logic [CW-1:0]         take;
	logic                  start_stream;
	logic [CNT_W-1:0]      cfg_v;
	logic [FW-1:0]         cap_new;

	assign pop  = head_valid && (state_q == ST_IDLE);
	assign idle = (state_q == ST_IDLE);

	// pointer steps, wrapping at the capacity
	assign wp_prev  = (wp_q == '0) ? PW'(cap_q - FW'(1)) : wp_q - PW'(1);
	assign wp_next  = ((FW'(wp_q) + FW'(1)) == cap_q) ? '0 : wp_q + PW'(1);
	assign dec_addr = (rd_addr == '0) ? PW'(cap_q - FW'(1)) : rd_addr - PW'(1);

	// words a read gets: min(requested, held)
	assign req   = CW'(head_count);
	assign avail = CW'(fill_q);
	assign take  = (req < avail) ? req : avail;

	// per-cycle operation select
	always_comb begin
		issue        = 1'b0;
		mem_we       = 1'b0;
		rd_addr      = rd_ptr_q;
		age_cur      = '0;
		has_cur      = 1'b0;
		last_cur     = 1'b1;
		fill_next    = fill_q;
		start_stream = 1'b0;
		if (state_q == ST_STREAM) begin
			issue    = 1'b1;
			has_cur  = 1'b1;
			age_cur  = age_q;
			last_cur = (age_q == last_age_q);
		end else if (head_valid) begin
			issue = 1'b1;
			case (head_op)
				OP_STORE: begin
					mem_we    = 1'b1;
					fill_next = (fill_q < cap_q) ? fill_q + FW'(1) : fill_q;
				end
				OP_READ: begin
					if (take != '0) begin
						has_cur      = 1'b1;
						rd_addr      = wp_prev;
						last_cur     = (take == CW'(1));
						start_stream = (take != CW'(1));
					end
				end
				default: begin
					last_cur = 1'b1;
				end
			endcase
		end
	end

	// capacity write, clamped to 1..DEPTH
	assign cfg_v   = (cfg_data == '0) ? CNT_W'(1) : cfg_data;
	assign cap_new = (int'(cfg_v) > DEPTH) ? FW'(DEPTH) : FW'(cfg_v);

	// ring memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wp_q] <= head_data;
		end
		rdata_s2 <= mem_q[rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wp_q       <= '0;
			fill_q     <= '0;
			cap_q      <= FW'(CAP_INIT);
			rd_ptr_q   <= '0;
			age_q      <= '0;
			last_age_q <= '0;
		end else if (cfg_we) begin
			cap_q  <= cap_new;
			wp_q   <= '0;
			fill_q <= '0;
		end else begin
			fill_q <= fill_next;
			if (mem_we) begin
				wp_q <= wp_next;
			end
			case (state_q)
				ST_IDLE: begin
					if (start_stream) begin
						state_q    <= ST_STREAM;
						rd_ptr_q   <= dec_addr;
						age_q      <= CW'(1);
						last_age_q <= take - CW'(1);
					end
				end
				ST_STREAM: begin
					rd_ptr_q <= dec_addr;
					age_q    <= age_q + CW'(1);
					if (last_cur) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else begin
			result_valid_s2 <= issue;
		end
	end

	// result fields, status taken after this step
	always_ff @(posedge clk) begin
		age_s2   <= AGE_W'(age_cur);
		has_s2   <= has_cur;
		last_s2  <= last_cur;
		fill_s2  <= CNT_W'(fill_next);
		empty_s2 <= (fill_next == '0);
		full_s2  <= (fill_next == cap_q);
	end

	assign result_valid = result_valid_s2;
	assign data_out     = has_s2 ? rdata_s2 : '0;
	assign age          = age_s2;
	assign has_data     = has_s2;
	assign last         = last_s2;
	assign fill_level   = fill_s2;
	assign is_empty     = empty_s2;
	assign is_full      = full_s2;

endmodule

`default_nettype wire

// ----- sv/overwriting_history_ring_buffer.sv -----
// ---------------------------------------------------------------------------
// overwriting_history_ring_buffer: ring that keeps the newest words
// Stores overwrite the oldest word once full; reads return the newest words,
// newest first, with age and a last mark.
//
//  channel  signals                               direction  flow
//  item     start, busy, cmd, data_in, read_count in         start & !busy
//  result   result_valid, data_out, age, has_data, out        one-cycle strobe
//           last, fill_level, is_empty, is_full
//  config   cfg_valid, cfg_ready, cfg_data        in         valid & ready
//
// A store gives one result; a read gives min(n, fill) results (one if it returns
// no data), streamed one word at a time through the single read port of the ring memory.
// With the queue empty, an item is held in the queue register and its first result in the result
// registers. Reset empties the ring and sets the capacity to 16 (or DEPTH if smaller).
// A two-entry queue lets intake run ahead while a read streams; busy rises
// when it is full. Results cannot be stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module overwriting_history_ring_buffer #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic                       cmd,
	input  wire logic [DATA_WIDTH-1:0]      data_in,
	input  wire logic [ohrb_pkg::CNT_W-1:0] read_count,
	output logic                            result_valid,
	output logic [DATA_WIDTH-1:0]           data_out,
	output logic [ohrb_pkg::AGE_W-1:0]      age,
	output logic                            has_data,
	output logic                            last,
	output logic [ohrb_pkg::CNT_W-1:0]      fill_level,
	output logic                            is_empty,
	output logic                            is_full,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [ohrb_pkg::CNT_W-1:0] cfg_data
);
	import ohrb_pkg::*;

	logic                  q_empty;
	logic                  head_valid;
	op_t                   head_op;
	logic [DATA_WIDTH-1:0] head_data;
	logic [CNT_W-1:0]      head_count;
	logic                  pop;
	logic                  back_idle;

	// intake and queue
	ohrb_front #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.data_in    (data_in),
		.read_count (read_count),
		.busy       (busy),
		.empty      (q_empty),
		.head_valid (head_valid),
		.head_op    (head_op),
		.head_data  (head_data),
		.head_count (head_count),
		.pop        (pop)
	);

	// capacity is taken only with nothing in flight
	assign cfg_ready = q_empty & back_idle;

	// ring engine
	ohrb_back #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_op      (head_op),
		.head_data    (head_data),
		.head_count   (head_count),
		.pop          (pop),
		.idle         (back_idle),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.data_out     (data_out),
		.age          (age),
		.has_data     (has_data),
		.last         (last),
		.fill_level   (fill_level),
		.is_empty     (is_empty),
		.is_full      (is_full)
	);

	// a data result never reaches past the words held
	a_age_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && has_data |-> ({1'b0, age} < fill_level))
		else $error("data result age beyond fill level");

	// capacity is never zero, so empty and full exclude each other
	a_empty_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(is_empty && is_full))
		else $error("ring reported empty and full at once");

	// a read stream continues in the next cycle with the next older word
	a_stream_next: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && has_data && !last |=>
			result_valid && has_data && (age == $past(age) + 4'd1))
		else $error("read stream broken before its last item");

	// configuration is only taken with the queue drained
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> !busy && !head_valid)
		else $error("capacity written while items are pending");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the overwriting history ring buffer
// Drives store and read items through the start/busy port and changes the
// capacity between phases. A scoreboard keeps its own copy of the ring,
// works out every status and data result of each accepted item, and checks
// each strobed result in order against it.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import ohrb_pkg::*;

	localparam int RING_DEPTH = 16;
	localparam int WORD_W     = 32;

	// one result as seen on the ports, in port order
	typedef struct packed {
		logic [WORD_W-1:0] data;
		logic [AGE_W-1:0]  age;
		logic              has_data;
		logic              last;
		logic [CNT_W-1:0]  fill_level;
		logic              is_empty;
		logic              is_full;
	} ring_result_t;

	// private copy of the ring plus the queue of results still owed
	class ring_scoreboard;
		logic [WORD_W-1:0] words [RING_DEPTH];
		int unsigned       wr_ptr;
		int unsigned       fill;
		int unsigned       cap;
		ring_result_t      owed_results [$];
		int unsigned       errors;
		int unsigned       results_seen;
		int unsigned       stores;
		int unsigned       reads;
		int unsigned       overwrites;
		int unsigned       longest_read;
		int unsigned       cap_writes;

		function new();
			cap = (CAP_RESET > RING_DEPTH) ? RING_DEPTH : CAP_RESET;
			wr_ptr = 0;
			fill = 0;
		endfunction

		// out-of-range values clamp to 1..DEPTH; any write empties the ring
		function void set_capacity(logic [CNT_W-1:0] v);
			int unsigned c;
			c = 32'(v);
			if (c < 1) c = 1;
			if (c > RING_DEPTH) c = RING_DEPTH;
			cap = c;
			wr_ptr = 0;
			fill = 0;
			cap_writes++;
		endfunction

		function ring_result_t status(logic [WORD_W-1:0] d, int unsigned a, logic has,
				logic lst);
			ring_result_t r;
			r.data = d;
			r.age = a[AGE_W-1:0];
			r.has_data = has;
			r.last = lst;
			r.fill_level = fill[CNT_W-1:0];
			r.is_empty = (fill == 0);
			r.is_full = (fill == cap);
			return r;
		endfunction

		// accepted item: update the ring and queue the results it owes
		function void note_item(logic c, logic [WORD_W-1:0] d, logic [CNT_W-1:0] n);
			int unsigned cnt;
			int unsigned idx;
			if (c == CMD_STORE) begin
				stores++;
				if (fill == cap) overwrites++;
				words[wr_ptr] = d;
				wr_ptr = (wr_ptr + 1) % cap;
				if (fill < cap) fill++;
				owed_results.push_back(status('0, 0, 1'b0, 1'b1));
			end else begin
				reads++;
				cnt = 32'(n);
				if (cnt > fill) cnt = fill;
				if (cnt > longest_read) longest_read = cnt;
				if (cnt == 0) begin
					owed_results.push_back(status('0, 0, 1'b0, 1'b1));
				end else begin
					// newest first, walking back from the write pointer
					for (int unsigned i = 0; i < cnt; i++) begin
						idx = (wr_ptr + cap - 1 - i) % cap;
						owed_results.push_back(status(words[idx], i, 1'b1, i + 1 == cnt));
					end
				end
			end
		endfunction

		function void check_result(ring_result_t got);
			ring_result_t want;
			results_seen++;
			if (owed_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result #%0d: data=%h age=%0d has=%b last=%b",
						results_seen, got.data, got.age, got.has_data, got.last);
				return;
			end
			want = owed_results.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) begin
					$display("result #%0d exp: data=%h age=%0d has=%b last=%b fill=%0d e=%b f=%b",
						results_seen, want.data, want.age, want.has_data, want.last,
						want.fill_level, want.is_empty, want.is_full);
					$display("result #%0d got: data=%h age=%0d has=%b last=%b fill=%0d e=%b f=%b",
						results_seen, got.data, got.age, got.has_data, got.last,
						got.fill_level, got.is_empty, got.is_full);
				end
			end
		endfunction

		function int pending();
			return owed_results.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                cmd;
	logic [WORD_W-1:0]   data_in;
	logic [CNT_W-1:0]    read_count;
	logic                result_valid;
	logic [WORD_W-1:0]   data_out;
	logic [AGE_W-1:0]    age;
	logic                has_data;
	logic                last;
	logic [CNT_W-1:0]    fill_level;
	logic                is_empty;
	logic                is_full;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CNT_W-1:0]    cfg_data;

	ring_scoreboard sb;

	overwriting_history_ring_buffer #(
		.DEPTH      (RING_DEPTH),
		.DATA_WIDTH (WORD_W)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.data_in      (data_in),
		.read_count   (read_count),
		.result_valid (result_valid),
		.data_out     (data_out),
		.age          (age),
		.has_data     (has_data),
		.last         (last),
		.fill_level   (fill_level),
		.is_empty     (is_empty),
		.is_full      (is_full),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog, far above the slowest legal run
	initial begin
		#2000000;
		$display("timeout: %0d results still owed", sb.pending());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// results are strobes; sample the pre-edge values
	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_result({data_out, age, has_data, last, fill_level, is_empty, is_full});
	end

	// hold the item until busy is low at an edge; start stays high after
	task automatic send_item(logic c, logic [WORD_W-1:0] d, logic [CNT_W-1:0] n);
		start <= 1'b1;
		cmd <= c;
		data_in <= d;
		read_count <= n;
		do @(posedge clk); while (busy);
		sb.note_item(c, d, n);
	endtask

	// drop start and wait until every owed result has come
	task automatic drain_ring();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// only called with the block drained
	task automatic write_capacity(logic [CNT_W-1:0] v);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_capacity(v);
	endtask

	// mostly stores so the ring fills and wraps; some counts past 16
	task automatic random_item();
		logic [CNT_W-1:0] n;
		if ($urandom_range(0, 99) < 10)
			n = CNT_W'($urandom_range(17, 31));
		else
			n = CNT_W'($urandom_range(0, 16));
		if ($urandom_range(0, 99) < 60)
			send_item(CMD_STORE, $urandom, n);
		else
			send_item(CMD_READ, $urandom, n);
	endtask

	int phase_cap  [4] = '{7, 16, 2, 12};
	int phase_idle [4] = '{0, 63, 0, 8};
	int wait_cycles;

	initial begin
		sb = new();
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= CMD_STORE;
		data_in <= '0;
		read_count <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty ring, zero count, data extremes, count past fill
		send_item(CMD_READ, 32'h0, 5'd1);
		send_item(CMD_READ, 32'hFFFF_FFFF, 5'd0);
		send_item(CMD_STORE, 32'h0000_0000, 5'd31);
		send_item(CMD_STORE, 32'hFFFF_FFFF, 5'd0);
		send_item(CMD_READ, 32'h0, 5'd0);
		send_item(CMD_READ, 32'h0, 5'd31);
		send_item(CMD_READ, 32'h0, 5'd1);
		drain_ring();

		// capacity 0 clamps to 1: every store overwrites the single word
		write_capacity(5'd0);
		send_item(CMD_STORE, 32'hA5A5_5A5A, 5'd0);
		send_item(CMD_STORE, 32'h5A5A_A5A5, 5'd0);
		send_item(CMD_READ, 32'h0, 5'd16);
		send_item(CMD_READ, 32'h0, 5'd1);
		drain_ring();

		// small ring wrapping once
		write_capacity(5'd3);
		for (int i = 0; i < 4; i++)
			send_item(CMD_STORE, 32'h1000_0000 + i, 5'd0);
		send_item(CMD_READ, 32'h0, 5'd16);
		send_item(CMD_READ, 32'h0, 5'd2);
		drain_ring();

		// capacity past DEPTH clamps to DEPTH
		write_capacity(5'd31);
		send_item(CMD_READ, 32'h0, 5'd16);
		drain_ring();

		// random phases; the receiver cannot stall, so phase 2 runs gap-free
		for (int p = 0; p < 4; p++) begin
			write_capacity(phase_cap[p][CNT_W-1:0]);
			for (int i = 0; i < 40; i++) begin
				random_item();
				if (p == 1 && i == 20) begin
					drain_ring();
				end else if ($urandom_range(0, 99) < phase_idle[p]) begin
					start <= 1'b0;
					if ($urandom_range(0, 9) == 0)
						repeat ($urandom_range(8, 20)) @(posedge clk);
					else
						repeat ($urandom_range(1, 6)) @(posedge clk);
				end
			end
			drain_ring();
		end

		// tail: wait out anything late, bounded
		start <= 1'b0;
		wait_cycles = 0;
		while (sb.pending() != 0 && wait_cycles < 2000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);

		if (sb.pending() != 0)
			$display("%0d results never arrived", sb.pending());
		$display("covered %0d stores (%0d overwrites) and %0d reads, longest read %0d words",
			sb.stores, sb.overwrites, sb.reads, sb.longest_read);
		$display("checked %0d results over %0d capacity writes, %0d errors",
			sb.results_seen, sb.cap_writes, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
sv/ohrb_pkg.sv
sv/ohrb_front.sv
sv/ohrb_back.sv
sv/overwriting_history_ring_buffer.sv
tb/sv/tb_top.sv
